@@ sv/tmbc_pkg.sv @@
// shared types and constants for the tile map box collision core
// no dependencies

package tmbc_pkg;

   // default storage sizes
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 32;
   localparam int DEF_TILE_KINDS  = 256;

   // request field widths
   localparam int KIND_W = 2;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int TILE_W = 8;
   localparam int POS_W  = 12;
   localparam int SIZE_W = 10;

   // register widths
   localparam int TSIZE_W = 7;
   localparam int WCOLS_W = 8;
   localparam int WROWS_W = 6;
   localparam int WIN_W   = 11;
   localparam int SCRX_W  = 13;
   localparam int SCRY_W  = 11;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // arithmetic widths
   localparam int SUM_W  = 15;
   localparam int MAG_W  = 14;
   localparam int PROD_W = 15;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_MAP   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FLAG  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TILE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WORLD_COLUMNS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WORLD_ROWS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_X      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SCROLL_Y      = 3'd7;

   typedef struct packed {
      logic               start;
      logic [MAG_W-1:0]   mag;
      logic [TSIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ sv/tmbc_divider.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on tmbc_pkg

module tmbc_divider
   import tmbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TSIZE_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0]   quo_ff, quo_in;
   logic [TSIZE_W-1:0] div_ff, div_in;

   logic [TSIZE_W:0] rem_sh;
   logic [TSIZE_W:0] rem_diff;
   logic             ge;

   assign rem_sh   = {rem_ff, quo_ff[MAG_W-1]};
   assign ge       = rem_sh >= {1'b0, div_ff};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MAG_W);
         rem_in  = '0;
         quo_in  = div_req.mag;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_diff[TSIZE_W-1:0] : rem_sh[TSIZE_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ sv/tilemap_box_collision_core.sv @@
// top level of the tile map box collision core: registers, map and flag memories, sequencer
// depends on tmbc_pkg and tmbc_divider

// Map writes, wall flag writes and unused kinds answer with collides low on the next
// cycle. A query runs through one shared restoring divider four times (left, top, right
// and bottom tile index), then checks bounds in the states S_BOUND, S_CMPX and S_CMPY
// with one small shared multiplier, then scans the covered tiles through the states
// S_ADDR, S_TILE and S_WALL, that is the map memory read and the wall flag memory read.
// A query stops early at the first wall or out of range tile. No request is taken while
// a query is in progress or while a response is stalled. Memories come up undefined;
// queries must only touch written cells and flags.

module tilemap_box_collision_core
   import tmbc_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int TILE_KINDS  = DEF_TILE_KINDS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [ROW_W-1:0]         req_map_row,
   input  logic [COL_W-1:0]         req_map_col,
   input  logic [TILE_W-1:0]        req_tile_number,
   input  logic                     req_wall_bit,
   input  logic signed [POS_W-1:0]  req_box_x,
   input  logic signed [POS_W-1:0]  req_box_y,
   input  logic [SIZE_W-1:0]        req_box_w,
   input  logic [SIZE_W-1:0]        req_box_h,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_collides,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int MAP_DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int MAP_AW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int WALL_DEPTH = (TILE_KINDS < (2 ** TILE_W)) ? TILE_KINDS : (2 ** TILE_W);
   localparam int WALL_AW    = $clog2(WALL_DEPTH);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIVGO   = 4'd1;
   localparam logic [3:0] S_DIVWAIT = 4'd2;
   localparam logic [3:0] S_BOUND   = 4'd3;
   localparam logic [3:0] S_CMPX    = 4'd4;
   localparam logic [3:0] S_CMPY    = 4'd5;
   localparam logic [3:0] S_ADDR    = 4'd6;
   localparam logic [3:0] S_TILE    = 4'd7;
   localparam logic [3:0] S_WALL    = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   localparam logic [1:0] Q_XMIN = 2'd0;
   localparam logic [1:0] Q_YMIN = 2'd1;
   localparam logic [1:0] Q_XMAX = 2'd2;
   localparam logic [1:0] Q_YMAX = 2'd3;

   // configuration
   logic [TSIZE_W-1:0] tile_width_ff;
   logic [TSIZE_W-1:0] tile_height_ff;
   logic [WCOLS_W-1:0] world_columns_ff;
   logic [WROWS_W-1:0] world_rows_ff;
   logic [WIN_W-1:0]   window_width_ff;
   logic [WIN_W-1:0]   window_height_ff;
   logic [SCRX_W-1:0]  scroll_x_ff;
   logic [SCRY_W-1:0]  scroll_y_ff;

   // control
   logic [3:0] state_ff, state_in;
   logic [1:0] div_sel_ff, div_sel_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // payload
   logic                    rsp_collides_ff, rsp_collides_in;
   logic                    hit_ff, hit_in;
   logic signed [POS_W-1:0] box_x_ff, box_y_ff;
   logic signed [SUM_W-1:0] sum_ff [4];
   logic signed [SUM_W-1:0] quot_ff [4];
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [WCOLS_W-1:0]      scan_i_ff, scan_i_in;
   logic [WROWS_W-1:0]      scan_j_ff, scan_j_in;
   logic [TILE_W-1:0]       map_rd_ff;
   logic                    flag_rd_ff;

   logic [TILE_W-1:0] map_mem  [MAP_DEPTH];
   logic              flag_mem [WALL_DEPTH];

   logic req_accept;
   logic rsp_free;
   logic is_query;

   logic [TSIZE_W-1:0] tw_eff, th_eff;

   logic signed [SUM_W-1:0] x_ext, y_ext, sx_ext, sy_ext, w_ext, h_ext;
   logic signed [SUM_W-1:0] sum_sel;
   logic signed [SUM_W-1:0] sum_abs;
   logic signed [SUM_W-1:0] quot_signed;
   logic                    sum_neg;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [WCOLS_W-1:0] mul_a;
   logic [TSIZE_W-1:0] mul_b;

   logic [31:0]       map_wr_lin, map_rd_lin;
   logic [MAP_AW-1:0] map_wr_addr, map_rd_addr;
   logic              map_wr_en, flag_wr_en;

   logic bound_bad;
   logic scan_out;
   logic last_i, last_j;
   logic no_wall;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign is_query   = (req_kind == KIND_QUERY);

   assign tw_eff = (tile_width_ff == '0) ? TSIZE_W'(1) : tile_width_ff;
   assign th_eff = (tile_height_ff == '0) ? TSIZE_W'(1) : tile_height_ff;

   // scrolled box edges
   assign x_ext  = SUM_W'(req_box_x);
   assign y_ext  = SUM_W'(req_box_y);
   assign sx_ext = $signed({{(SUM_W-SCRX_W){1'b0}}, scroll_x_ff});
   assign sy_ext = $signed({{(SUM_W-SCRY_W){1'b0}}, scroll_y_ff});
   assign w_ext  = $signed({{(SUM_W-SIZE_W){1'b0}}, req_box_w});
   assign h_ext  = $signed({{(SUM_W-SIZE_W){1'b0}}, req_box_h});

   // divider operand, signed magnitude around the unsigned unit
   assign sum_sel     = sum_ff[div_sel_ff];
   assign sum_neg     = sum_sel[SUM_W-1];
   assign sum_abs     = sum_neg ? -sum_sel : sum_sel;
   assign quot_signed = sum_neg ? -$signed({1'b0, div_rsp.quotient})
                                : $signed({1'b0, div_rsp.quotient});

   assign div_req.start   = (state_ff == S_DIVGO);
   assign div_req.mag     = sum_abs[MAG_W-1:0];
   assign div_req.divisor = div_sel_ff[0] ? th_eff : tw_eff;

   tmbc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // shared multiplier for the world size in pixels
   assign mul_a   = (state_ff == S_BOUND) ? world_columns_ff
                                          : {{(WCOLS_W-WROWS_W){1'b0}}, world_rows_ff};
   assign mul_b   = (state_ff == S_BOUND) ? tw_eff : th_eff;
   assign prod_in = PROD_W'(mul_a * mul_b);

   // memory addressing
   assign map_wr_lin  = 32'(req_map_row) * 32'(MAX_COLUMNS) + 32'(req_map_col);
   assign map_wr_addr = map_wr_lin[MAP_AW-1:0];
   assign map_rd_lin  = 32'(scan_j_ff) * 32'(MAX_COLUMNS) + 32'(scan_i_ff);
   assign map_rd_addr = map_rd_lin[MAP_AW-1:0];

   assign map_wr_en  = req_accept && (req_kind == KIND_MAP)
                       && (32'(req_map_row) < 32'(MAX_ROWS))
                       && (32'(req_map_col) < 32'(MAX_COLUMNS));
   assign flag_wr_en = req_accept && (req_kind == KIND_FLAG)
                       && (32'(req_tile_number) < 32'(TILE_KINDS));

   // span and origin checks
   always_comb begin
      bound_bad = quot_ff[Q_XMIN][SUM_W-1] || quot_ff[Q_YMIN][SUM_W-1]
                  || quot_ff[Q_XMAX][SUM_W-1] || quot_ff[Q_YMAX][SUM_W-1]
                  || (quot_ff[Q_XMAX][MAG_W-1:0] >= MAG_W'(world_columns_ff))
                  || (quot_ff[Q_YMAX][MAG_W-1:0] >= MAG_W'(world_rows_ff))
                  || box_x_ff[POS_W-1] || box_y_ff[POS_W-1]
                  || (box_x_ff[WIN_W-1:0] >= window_width_ff)
                  || (box_y_ff[WIN_W-1:0] >= window_height_ff);
   end

   assign scan_out = (32'(scan_i_ff) >= 32'(MAX_COLUMNS)) || (32'(scan_j_ff) >= 32'(MAX_ROWS));
   assign last_i   = (scan_i_ff == quot_ff[Q_XMAX][WCOLS_W-1:0]);
   assign last_j   = (scan_j_ff == quot_ff[Q_YMAX][WROWS_W-1:0]);
   assign no_wall  = (32'(map_rd_ff) >= 32'(TILE_KINDS));

   always_comb begin
      state_in        = state_ff;
      div_sel_in      = div_sel_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_collides_in = rsp_collides_ff;
      hit_in          = hit_ff;
      scan_i_in       = scan_i_ff;
      scan_j_in       = scan_j_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (is_query) begin
                  div_sel_in = Q_XMIN;
                  state_in   = S_DIVGO;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_collides_in = 1'b0;
               end
            end
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_rsp.done) begin
               div_sel_in = div_sel_ff + 2'd1;
               state_in   = (div_sel_ff == Q_YMAX) ? S_BOUND : S_DIVGO;
            end
         end
         S_BOUND: begin
            if (bound_bad) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_CMPX;
            end
         end
         S_CMPX: begin
            if (PROD_W'(box_x_ff[WIN_W-1:0]) >= prod_ff) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_CMPY;
            end
         end
         S_CMPY: begin
            if (PROD_W'(box_y_ff[WIN_W-1:0]) >= prod_ff) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               scan_i_in = quot_ff[Q_XMIN][WCOLS_W-1:0];
               scan_j_in = quot_ff[Q_YMIN][WROWS_W-1:0];
               state_in  = S_ADDR;
            end
         end
         S_ADDR: begin
            if (scan_out) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_TILE;
            end
         end
         S_TILE, S_WALL: begin
            if ((state_ff == S_TILE) && !no_wall) begin
               state_in = S_WALL;
            end else if ((state_ff == S_WALL) && flag_rd_ff) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else if (last_i && last_j) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else if (last_j) begin
               scan_i_in = scan_i_ff + WCOLS_W'(1);
               scan_j_in = quot_ff[Q_YMIN][WROWS_W-1:0];
               state_in  = S_ADDR;
            end else begin
               scan_j_in = scan_j_ff + WROWS_W'(1);
               state_in  = S_ADDR;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_collides_in = hit_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         div_sel_ff       <= Q_XMIN;
         rsp_valid_ff     <= 1'b0;
         tile_width_ff    <= TSIZE_W'(16);
         tile_height_ff   <= TSIZE_W'(16);
         world_columns_ff <= WCOLS_W'(128);
         world_rows_ff    <= WROWS_W'(32);
         window_width_ff  <= WIN_W'(640);
         window_height_ff <= WIN_W'(480);
         scroll_x_ff      <= '0;
         scroll_y_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         div_sel_ff   <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_TILE_WIDTH:    tile_width_ff    <= csr_wdata[TSIZE_W-1:0];
               REG_TILE_HEIGHT:   tile_height_ff   <= csr_wdata[TSIZE_W-1:0];
               REG_WORLD_COLUMNS: world_columns_ff <= csr_wdata[WCOLS_W-1:0];
               REG_WORLD_ROWS:    world_rows_ff    <= csr_wdata[WROWS_W-1:0];
               REG_WINDOW_WIDTH:  window_width_ff  <= csr_wdata[WIN_W-1:0];
               REG_WINDOW_HEIGHT: window_height_ff <= csr_wdata[WIN_W-1:0];
               REG_SCROLL_X:      scroll_x_ff      <= csr_wdata[SCRX_W-1:0];
               REG_SCROLL_Y:      scroll_y_ff      <= csr_wdata[SCRY_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_collides_ff <= rsp_collides_in;
      hit_ff          <= hit_in;
      scan_i_ff       <= scan_i_in;
      scan_j_ff       <= scan_j_in;
      if (state_ff == S_BOUND || state_ff == S_CMPX) begin
         prod_ff <= prod_in;
      end
      if (req_accept && is_query) begin
         box_x_ff         <= req_box_x;
         box_y_ff         <= req_box_y;
         sum_ff[Q_XMIN]   <= x_ext + sx_ext;
         sum_ff[Q_YMIN]   <= y_ext + sy_ext;
         sum_ff[Q_XMAX]   <= x_ext + w_ext + sx_ext;
         sum_ff[Q_YMAX]   <= y_ext + h_ext + sy_ext;
      end
      if (state_ff == S_DIVWAIT && div_rsp.done) begin
         quot_ff[div_sel_ff] <= quot_signed;
      end
   end

   // tile map and wall flag memories
   always_ff @(posedge clock) begin
      if (map_wr_en) begin
         map_mem[map_wr_addr] <= req_tile_number;
      end
      if (state_ff == S_ADDR) begin
         map_rd_ff <= map_mem[map_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (flag_wr_en) begin
         flag_mem[req_tile_number[WALL_AW-1:0]] <= req_wall_bit;
      end
      if (state_ff == S_TILE) begin
         flag_rd_ff <= flag_mem[map_rd_ff[WALL_AW-1:0]];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_collides = rsp_collides_ff;

`ifndef SYNTHESIS
   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind != KIND_QUERY |=> rsp_valid && !rsp_collides)
      else $error("write request without a clear response");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIVWAIT)
      else $error("divider finished outside its wait state");

   a_scan_span_positive: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADDR |-> !quot_ff[Q_XMIN][SUM_W-1] && !quot_ff[Q_YMAX][SUM_W-1])
      else $error("tile scan started on a negative span");

   a_scan_in_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADDR |-> scan_i_ff <= quot_ff[Q_XMAX][WCOLS_W-1:0]
                             && scan_j_ff <= quot_ff[Q_YMAX][WROWS_W-1:0])
      else $error("tile scan ran past the covered span");
`endif

endmodule
